@@ src/hpn_pkg.sv @@
// Shared constants and types for the 4D hyperplane normal core.
`default_nettype none

package hpn_pkg;

    localparam int LIMB_W    = 32;   // multiplier partial product slice
    localparam int FRAC_BITS = 16;   // Q16.16 inputs
    localparam int CFG_W     = 31;   // cell size register width
    localparam int IDX_W     = 24;   // voxel index width
    localparam int NCOMP     = 5;    // A, -B, -C, D, F
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SZ = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 31'd65536;  // 1.0

    typedef struct packed {
        logic             vld;
        logic             zero;
        logic [NCOMP-1:0] neg;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

`default_nettype wire

@@ src/hpn_mul.sv @@
// Pipelined signed multiplier built from 32x32 partial products: magnitudes, partial products, row sums, total, sign.
`default_nettype none

module hpn_mul import hpn_pkg::*; #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int NA   = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB   = (BW + LIMB_W - 1) / LIMB_W;
    localparam int PW   = AW + BW;
    localparam int RW   = (NB + 1) * LIMB_W;
    localparam int SUMW = (NA + NB) * LIMB_W;

    logic [NA*LIMB_W-1:0]   r_ma, n_ma;
    logic [NB*LIMB_W-1:0]   r_mb, n_mb;
    logic [AW-1:0]          w_abs_a;
    logic [BW-1:0]          w_abs_b;
    logic [2*LIMB_W-1:0]    r_pp [NA][NB];
    logic [RW-1:0]          r_row [NA];
    logic [RW-1:0]          n_row [NA];
    logic [SUMW-1:0]        r_sum, n_sum;
    logic signed [PW-1:0]   r_p;
    logic [4:1]             r_neg;

    // stage 1: magnitudes
    always_comb begin
        w_abs_a = i_a[AW-1] ? -i_a : i_a;
        w_abs_b = i_b[BW-1] ? -i_b : i_b;
        n_ma = '0;
        n_ma[AW-1:0] = w_abs_a;
        n_mb = '0;
        n_mb[BW-1:0] = w_abs_b;
    end

    // stage 3: row sums, stage 4: total
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (RW'(r_pp[i][j]) << (LIMB_W * j));
            end
        end
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (SUMW'(r_row[i]) << (LIMB_W * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma     <= n_ma;
            r_mb     <= n_mb;
            r_neg[1] <= i_a[AW-1] ^ i_b[BW-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= r_ma[i*LIMB_W +: LIMB_W] * r_mb[j*LIMB_W +: LIMB_W];
                end
            end
            r_neg[2] <= r_neg[1];
            r_row    <= n_row;
            r_neg[3] <= r_neg[2];
            r_sum    <= n_sum;
            r_neg[4] <= r_neg[3];
            r_p      <= r_neg[4] ? -$signed(r_sum[PW-1:0]) : $signed(r_sum[PW-1:0]);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ src/hpn_step.sv @@
// One result bit of the rounded normalization for all five components.
`default_nettype none

module hpn_step import hpn_pkg::*; #(
    parameter int SW  = 264,
    parameter int EW  = 330,
    parameter int VW  = 297,
    parameter int QW  = 31,
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_tag                 i_tag,
    input  logic [SW-1:0]        i_s,
    input  logic signed [EW-1:0] i_e [NCOMP],
    input  logic signed [VW-1:0] i_v [NCOMP],
    input  logic [QW-1:0]        i_q [NCOMP],
    output t_tag                 o_tag,
    output logic [SW-1:0]        o_s,
    output logic signed [EW-1:0] o_e [NCOMP],
    output logic signed [VW-1:0] o_v [NCOMP],
    output logic [QW-1:0]        o_q [NCOMP]
);

    logic signed [EW-1:0] w_dlt [NCOMP];
    logic signed [EW-1:0] w_tst [NCOMP];
    logic signed [EW-1:0] n_e [NCOMP];
    logic signed [VW-1:0] n_v [NCOMP];
    logic [QW-1:0]        n_q [NCOMP];
    logic signed [EW-1:0] r_e [NCOMP];
    logic signed [VW-1:0] r_v [NCOMP];
    logic [QW-1:0]        r_q [NCOMP];
    logic [SW-1:0]        r_s;
    t_tag                 r_tag;

    // residual E = 4 m^2 2^(2F) - u^2 s, V = u s, u = 2q - 1
    always_comb begin
        for (int k = 0; k < NCOMP; k++) begin
            w_dlt[k] = (EW'(i_v[k]) <<< (BIT + 2)) + $signed(EW'(i_s) << (2 * BIT + 2));
            w_tst[k] = i_e[k] - w_dlt[k];
            n_e[k] = i_e[k];
            n_v[k] = i_v[k];
            n_q[k] = i_q[k];
            if (!w_tst[k][EW-1]) begin
                n_e[k] = w_tst[k];
                n_v[k] = i_v[k] + $signed(VW'(i_s) << (BIT + 1));
                n_q[k] = i_q[k] | (QW'(1) << BIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= i_s;
            r_e <= n_e;
            r_v <= n_v;
            r_q <= n_q;
        end
    end

    assign o_tag = r_tag;
    assign o_s   = r_s;
    assign o_e   = r_e;
    assign o_v   = r_v;
    assign o_q   = r_q;

endmodule

`default_nettype wire

@@ src/hyperplane_normal_4d_core.sv @@
// Top level: per-voxel 4D hyperplane normal, fully pipelined.
//
//  channel | direction | handshake                  | item
//  --------+-----------+----------------------------+-------------------------------
//  input   | in        | i_valid / o_stall          | index, corner, four samples
//  result  | out       | o_valid / i_stall          | index, five normals, zero flag
//  config  | in        | i_cfg_valid / o_cfg_ready  | register index, cell size
//
//  One item per cycle unless the output stalls. Pipeline: 22 stages of exact
//  wide products (four chained 5-stage multipliers plus sums), an init stage,
//  DATA_WIDTH-1 normalization stages (one result bit each), one output stage.
//  Reset is synchronous, active low; it clears valid bits and sets cell sizes to 1.0.
//  A stall at the output freezes the whole pipeline; no item is lost or doubled.
`default_nettype none

module hyperplane_normal_4d_core import hpn_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input items
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [IDX_W-1:0]             i_item_index,
    input  logic signed [DATA_WIDTH-1:0] i_corner_x,
    input  logic signed [DATA_WIDTH-1:0] i_corner_y,
    input  logic signed [DATA_WIDTH-1:0] i_corner_z,
    input  logic signed [DATA_WIDTH-1:0] i_value_at_corner,
    input  logic signed [DATA_WIDTH-1:0] i_value_step_x,
    input  logic signed [DATA_WIDTH-1:0] i_value_step_y,
    input  logic signed [DATA_WIDTH-1:0] i_value_step_z,
    // result items
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [IDX_W-1:0]             o_result_index,
    output logic signed [DATA_WIDTH-1:0] o_normal_a,
    output logic signed [DATA_WIDTH-1:0] o_normal_b,
    output logic signed [DATA_WIDTH-1:0] o_normal_c,
    output logic signed [DATA_WIDTH-1:0] o_normal_d,
    output logic signed [DATA_WIDTH-1:0] o_normal_f,
    output logic                         o_zero_norm,
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data
);

    localparam int DW   = DATA_WIDTH;
    localparam int OF   = DW - 2;               // output fraction bits
    localparam int DDW  = DW + 1;               // sample differences
    localparam int CSW  = CFG_W + 1;            // cell size as signed operand
    localparam int P2W  = 2 * CSW;              // product of two cell sizes
    localparam int TW   = DDW + P2W;            // difference times two sizes
    localparam int P3W  = P2W + CSW;            // product of three sizes
    localparam int F1W  = DW + TW;
    localparam int F4W  = DW + P3W;
    localparam int CW   = ((F1W > F4W) ? F1W : F4W) + 2;   // component width
    localparam int SQW  = 2 * CW;
    localparam int SW   = 2 * CW + 2;           // sum of squares
    localparam int EW   = 2 * CW + 2 * OF + 8;  // residual
    localparam int VW   = 2 * CW + OF + 5;
    localparam int QW   = DW - 1;               // result magnitude
    localparam int NST  = OF + 1;               // normalization stages
    localparam logic signed [DW-1:0] NLIM = DW'(1) <<< OF;

    logic en;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_cfg_sx, r_cfg_sy, r_cfg_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sx <= CFG_RESET;
            r_cfg_sy <= CFG_RESET;
            r_cfg_sz <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SX:  r_cfg_sx <= i_cfg_data;
                CFG_SY:  r_cfg_sy <= i_cfg_data;
                CFG_SZ:  r_cfg_sz <= i_cfg_data;
                default: ;   // unmapped index, dropped
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic signed [CSW-1:0] w_sx, w_sy, w_sz;
    assign w_sx = $signed({1'b0, r_cfg_sx});
    assign w_sy = $signed({1'b0, r_cfg_sy});
    assign w_sz = $signed({1'b0, r_cfg_sz});

    // ---------------- stage 1..22 control ----------------
    logic             r_vld [1:22];
    logic [IDX_W-1:0] r_idx [1:22];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int st = 1; st <= 22; st++) r_vld[st] <= 1'b0;
        end else if (en) begin
            r_vld[1] <= i_valid;
            for (int st = 2; st <= 22; st++) r_vld[st] <= r_vld[st-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx[1] <= i_item_index;
            for (int st = 2; st <= 22; st++) r_idx[st] <= r_idx[st-1];
        end
    end

    // ---------------- stage 1: differences, operand delay ----------------
    logic signed [DDW-1:0] r_d1 [1:5], r_d2 [1:5], r_d3 [1:5];
    logic signed [DW-1:0]  r_x [1:10], r_y [1:10], r_z [1:10], r_w0 [1:10];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[1] <= DDW'(i_value_step_x) - DDW'(i_value_at_corner);
            r_d2[1] <= DDW'(i_value_step_y) - DDW'(i_value_at_corner);
            r_d3[1] <= DDW'(i_value_step_z) - DDW'(i_value_at_corner);
            r_x[1]  <= i_corner_x;
            r_y[1]  <= i_corner_y;
            r_z[1]  <= i_corner_z;
            r_w0[1] <= i_value_at_corner;
            for (int st = 2; st <= 5; st++) begin
                r_d1[st] <= r_d1[st-1];
                r_d2[st] <= r_d2[st-1];
                r_d3[st] <= r_d3[st-1];
            end
            for (int st = 2; st <= 10; st++) begin
                r_x[st]  <= r_x[st-1];
                r_y[st]  <= r_y[st-1];
                r_z[st]  <= r_z[st-1];
                r_w0[st] <= r_w0[st-1];
            end
        end
    end

    // ---------------- products: sizes (0->5), terms (5->10), F terms (10->15) ----
    logic signed [P2W-1:0] w_syz, w_sxz, w_sxy;
    logic signed [TW-1:0]  w_t1, w_t2, w_t3;
    logic signed [P3W-1:0] w_sxyz;
    logic signed [F1W-1:0] w_f1, w_f2, w_f3;
    logic signed [F4W-1:0] w_f4;

    hpn_mul #(.AW(CSW), .BW(CSW)) u_syz (.i_clk(i_clk), .i_en(en),
        .i_a(w_sy), .i_b(w_sz), .o_p(w_syz));
    hpn_mul #(.AW(CSW), .BW(CSW)) u_sxz (.i_clk(i_clk), .i_en(en),
        .i_a(w_sx), .i_b(w_sz), .o_p(w_sxz));
    hpn_mul #(.AW(CSW), .BW(CSW)) u_sxy (.i_clk(i_clk), .i_en(en),
        .i_a(w_sx), .i_b(w_sy), .o_p(w_sxy));

    hpn_mul #(.AW(DDW), .BW(P2W)) u_t1 (.i_clk(i_clk), .i_en(en),
        .i_a(r_d1[5]), .i_b(w_syz), .o_p(w_t1));
    hpn_mul #(.AW(DDW), .BW(P2W)) u_t2 (.i_clk(i_clk), .i_en(en),
        .i_a(r_d2[5]), .i_b(w_sxz), .o_p(w_t2));
    hpn_mul #(.AW(DDW), .BW(P2W)) u_t3 (.i_clk(i_clk), .i_en(en),
        .i_a(r_d3[5]), .i_b(w_sxy), .o_p(w_t3));
    hpn_mul #(.AW(P2W), .BW(CSW)) u_sxyz (.i_clk(i_clk), .i_en(en),
        .i_a(w_sxy), .i_b(w_sz), .o_p(w_sxyz));

    hpn_mul #(.AW(DW), .BW(TW)) u_f1 (.i_clk(i_clk), .i_en(en),
        .i_a(r_x[10]), .i_b(w_t1), .o_p(w_f1));
    hpn_mul #(.AW(DW), .BW(TW)) u_f2 (.i_clk(i_clk), .i_en(en),
        .i_a(r_y[10]), .i_b(w_t2), .o_p(w_f2));
    hpn_mul #(.AW(DW), .BW(TW)) u_f3 (.i_clk(i_clk), .i_en(en),
        .i_a(r_z[10]), .i_b(w_t3), .o_p(w_f3));
    hpn_mul #(.AW(DW), .BW(P3W)) u_f4 (.i_clk(i_clk), .i_en(en),
        .i_a(r_w0[10]), .i_b(w_sxyz), .o_p(w_f4));

    // ---------------- stage 11..16: components on the 2^-64 scale ----------------
    logic signed [CW-1:0] r_c [4][11:16];
    logic signed [CW-1:0] r_f;
    logic signed [CW-1:0] w_cm [NCOMP];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c[0][11] <= -(CW'(w_t1) <<< FRAC_BITS);
            r_c[1][11] <= -(CW'(w_t2) <<< FRAC_BITS);
            r_c[2][11] <=   CW'(w_t3) <<< FRAC_BITS;
            r_c[3][11] <= -(CW'(w_sxyz) <<< FRAC_BITS);
            for (int k = 0; k < 4; k++) begin
                for (int st = 12; st <= 16; st++) r_c[k][st] <= r_c[k][st-1];
            end
            r_f <= CW'(w_f1) + CW'(w_f2) + CW'(w_f3) - CW'(w_f4);
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) w_cm[k] = r_c[k][16];
        w_cm[4] = r_f;
    end

    // ---------------- squares (16->21), sum (22) ----------------
    logic signed [SQW-1:0] w_sq [NCOMP];
    logic [SQW-1:0]        r_sq [NCOMP];
    logic [NCOMP-1:0]      r_sgn [17:22];
    logic [SW-1:0]         r_s, w_ssum;

    for (genvar k = 0; k < NCOMP; k++) begin : g_sq
        hpn_mul #(.AW(CW), .BW(CW)) u_sq (.i_clk(i_clk), .i_en(en),
            .i_a(w_cm[k]), .i_b(w_cm[k]), .o_p(w_sq[k]));
    end

    always_comb begin
        w_ssum = '0;
        for (int k = 0; k < NCOMP; k++) w_ssum = w_ssum + SW'($unsigned(w_sq[k]));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NCOMP; k++) begin
                r_sgn[17][k] <= w_cm[k][CW-1];
                r_sq[k]      <= $unsigned(w_sq[k]);
            end
            for (int st = 18; st <= 22; st++) r_sgn[st] <= r_sgn[st-1];
            r_s <= w_ssum;
        end
    end

    // ---------------- stage 23: residual setup ----------------
    // Result q is the largest value with (2q-1)^2 s <= 4 m^2 2^(2*OF):
    // |m| 2^OF / sqrt(s) rounded to nearest, halves away from zero.
    t_tag                 w_tg [NST+1];
    logic [SW-1:0]        w_s  [NST+1];
    logic signed [EW-1:0] w_e  [NST+1][NCOMP];
    logic signed [VW-1:0] w_v  [NST+1][NCOMP];
    logic [QW-1:0]        w_q  [NST+1][NCOMP];

    t_tag                 r_tg0;
    logic [SW-1:0]        r_s0;
    logic signed [EW-1:0] r_e0 [NCOMP];
    logic signed [VW-1:0] r_v0 [NCOMP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tg0 <= '0;
        end else if (en) begin
            r_tg0.vld  <= r_vld[22];
            r_tg0.zero <= (r_s == '0);
            r_tg0.neg  <= r_sgn[22];
            r_tg0.idx  <= r_idx[22];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= r_s;
            for (int k = 0; k < NCOMP; k++) begin
                r_e0[k] <= (EW'(r_sq[k]) << (2 * OF + 2)) - EW'(r_s);
                r_v0[k] <= -$signed(VW'(r_s));
            end
        end
    end

    assign w_tg[0] = r_tg0;
    assign w_s[0]  = r_s0;
    assign w_e[0]  = r_e0;
    assign w_v[0]  = r_v0;
    assign w_q[0]  = '{default: '0};

    // ---------------- normalization, one bit per stage, MSB first ----------------
    for (genvar g = 0; g < NST; g++) begin : g_step
        hpn_step #(.SW(SW), .EW(EW), .VW(VW), .QW(QW), .BIT(OF - g)) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_tag  (w_tg[g]),
            .i_s    (w_s[g]),
            .i_e    (w_e[g]),
            .i_v    (w_v[g]),
            .i_q    (w_q[g]),
            .o_tag  (w_tg[g+1]),
            .o_s    (w_s[g+1]),
            .o_e    (w_e[g+1]),
            .o_v    (w_v[g+1]),
            .o_q    (w_q[g+1])
        );
    end

    // ---------------- output register ----------------
    logic                 r_out_vld;
    logic [IDX_W-1:0]     r_out_idx;
    logic                 r_out_zero;
    logic signed [DW-1:0] r_norm [NCOMP];
    t_tag                 w_last;

    assign w_last = w_tg[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_idx  <= w_last.idx;
            r_out_zero <= w_last.zero;
            for (int k = 0; k < NCOMP; k++) begin
                if (w_last.zero) begin
                    r_norm[k] <= '0;
                end else if (w_last.neg[k]) begin
                    r_norm[k] <= -$signed(DW'(w_q[NST][k]));
                end else begin
                    r_norm[k] <= $signed(DW'(w_q[NST][k]));
                end
            end
        end
    end

    // whole pipeline advances unless a finished item is held at the output
    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;

    assign o_valid        = r_out_vld;
    assign o_result_index = r_out_idx;
    assign o_zero_norm    = r_out_zero;
    assign o_normal_a     = r_norm[0];
    assign o_normal_b     = r_norm[1];
    assign o_normal_c     = r_norm[2];
    assign o_normal_d     = r_norm[3];
    assign o_normal_f     = r_norm[4];

    // ---------------- checks ----------------
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_norm |-> o_normal_a == '0 && o_normal_b == '0 &&
            o_normal_c == '0 && o_normal_d == '0 && o_normal_f == '0)
        else $error("zero norm with nonzero normal");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_a <= NLIM && o_normal_a >= -NLIM &&
            o_normal_f <= NLIM && o_normal_f >= -NLIM)
        else $error("normal component beyond unit range");

    a_vld_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> r_vld[2] == $past(r_vld[1]))
        else $error("valid bit lost in front stages");

    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_last.vld))
        else $error("result without item in last stage");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_tg0) && $stable(w_last))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
